// ----- rtl/core/fr_pkg.sv -----
package fr_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	// bit positions in the result tuser
	localparam int USER_CHANGED   = 0;
	localparam int USER_UNDEFINED = 1;
	localparam int USER_WIDTH     = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_DONE
	} fr_state_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic skip_div;
		logic div_done;
	} dp_sts_t;

endpackage

// ----- rtl/core/fr_ctrl.sv -----
module fr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output fr_pkg::dp_cmd_t cmd,
	input  fr_pkg::dp_sts_t sts
);
	import fr_pkg::*;

	fr_state_t state_q;
	fr_state_t state_d;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_GCD;
			end
			ST_GCD: begin
				if (sts.gcd_done) state_d = sts.skip_div ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_GCD: begin
				cmd.gcd_step  = !sts.gcd_done;
				cmd.div_start = sts.gcd_done && !sts.skip_div;
			end
			ST_DIV: begin
				cmd.div_step = !sts.div_done;
			end
			ST_DONE: begin
				// move the result out once the output slot is free
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/fr_datapath.sv -----
module fr_datapath #(
	parameter int VALUE_WIDTH = fr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  fr_pkg::dp_cmd_t        cmd,
	output fr_pkg::dp_sts_t        sts,
	input  logic [VALUE_WIDTH-1:0] numerator,
	input  logic [VALUE_WIDTH-1:0] denominator,
	input  logic                   last_in,
	output logic [VALUE_WIDTH-1:0] reduced_numerator,
	output logic [VALUE_WIDTH-1:0] reduced_denominator,
	output logic                   changed,
	output logic                   undefined_fraction,
	output logic                   last_out
);
	import fr_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int KW = $clog2(W + 1);

	logic [W-1:0]  num_q, den_q;
	logic          last_q;
	logic [W-1:0]  a_q, b_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  g_q;
	logic [W-1:0]  rn_q, rd_q;
	logic [W-1:0]  qn_q, qd_q;
	logic [KW-1:0] cnt_q;

	logic [W-1:0] num_mag, den_mag;
	logic [W-1:0] diff;
	logic         a_ge_b;
	logic [W-1:0] g_w;
	logic [W:0]   rn_sh, rd_sh;
	logic         rn_fit, rd_fit;
	logic [W-1:0] qn_signed, qd_signed;
	logic         both_zero;

	// the most negative value maps to the unsigned power of two
	assign num_mag = num_q[W-1] ? (~num_q + W'(1)) : num_q;
	assign den_mag = den_q[W-1] ? (~den_q + W'(1)) : den_q;

	assign a_ge_b = (a_q >= b_q);
	assign diff   = a_ge_b ? (a_q - b_q) : (b_q - a_q);
	assign g_w    = (a_q | b_q) << k_q;

	assign both_zero    = (num_q == '0) && (den_q == '0);
	assign sts.gcd_done = (a_q == '0) || (b_q == '0);
	assign sts.skip_div = (g_w[W-1:1] == '0);
	assign sts.div_done = (cnt_q == KW'(W));

	assign rn_sh  = {rn_q, qn_q[W-1]};
	assign rd_sh  = {rd_q, qd_q[W-1]};
	assign rn_fit = (rn_sh >= {1'b0, g_q});
	assign rd_fit = (rd_sh >= {1'b0, g_q});

	assign qn_signed = num_q[W-1] ? (~qn_q + W'(1)) : qn_q;
	assign qd_signed = den_q[W-1] ? (~qd_q + W'(1)) : qd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= numerator;
			den_q  <= denominator;
			last_q <= last_in;
		end

		if (cmd.load) begin
			a_q <= numerator[W-1] ? (~numerator + W'(1)) : numerator;
			b_q <= denominator[W-1] ? (~denominator + W'(1)) : denominator;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			// binary gcd: strip common twos into k, then odd-odd subtract
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_ge_b) begin
				a_q <= diff >> 1;
			end else begin
				b_q <= diff >> 1;
			end
		end

		if (cmd.div_start) begin
			g_q   <= g_w;
			qn_q  <= num_mag;
			qd_q  <= den_mag;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rn_q  <= rn_fit ? W'(rn_sh - {1'b0, g_q}) : rn_sh[W-1:0];
			rd_q  <= rd_fit ? W'(rd_sh - {1'b0, g_q}) : rd_sh[W-1:0];
			qn_q  <= {qn_q[W-2:0], rn_fit};
			qd_q  <= {qd_q[W-2:0], rd_fit};
			cnt_q <= cnt_q + KW'(1);
		end

		if (cmd.out_load) begin
			last_out           <= last_q;
			undefined_fraction <= both_zero;
			if (sts.skip_div) begin
				reduced_numerator   <= num_q;
				reduced_denominator <= den_q;
				changed             <= 1'b0;
			end else begin
				reduced_numerator   <= qn_signed;
				reduced_denominator <= qd_signed;
				changed             <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/fraction_reducer_top.sv -----
// Flow: a load step, then binary gcd steps (one shift or subtract per cycle), then exact
// division of both magnitudes by the gcd when the divisor exceeds one, then a step into
// the output register.
// Throughput: one item at a time, set by the shared gcd and divider loops; the next item
// is taken while the previous result still waits in the output register.
// Reset (arst_n low) clears the controller state and the output valid flag.
module fraction_reducer_top #(
	parameter int VALUE_WIDTH = fr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [2*VALUE_WIDTH-1:0]           s_tdata,  // numerator, denominator
	input  logic                               s_tlast,  // last_in
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [2*VALUE_WIDTH-1:0]           m_tdata,  // reduced_numerator, reduced_denominator
	output logic [fr_pkg::USER_WIDTH-1:0]      m_tuser,  // changed, undefined_fraction
	output logic                               m_tlast   // last_out
);
	import fr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	logic [VALUE_WIDTH-1:0] red_num, red_den;
	logic                   changed, undefined_fraction;

	fr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fr_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk                 (clk),
		.cmd                 (cmd),
		.sts                 (sts),
		.numerator           (s_tdata[VALUE_WIDTH-1:0]),
		.denominator         (s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
		.last_in             (s_tlast),
		.reduced_numerator   (red_num),
		.reduced_denominator (red_den),
		.changed             (changed),
		.undefined_fraction  (undefined_fraction),
		.last_out            (m_tlast)
	);

	assign m_tdata                 = {red_den, red_num};
	assign m_tuser[USER_CHANGED]   = changed;
	assign m_tuser[USER_UNDEFINED] = undefined_fraction;

	a_load_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is at work");

	a_undef_not_changed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[USER_UNDEFINED]) |-> (!m_tuser[USER_CHANGED] && m_tdata == '0))
		else $error("zero over zero result is not a plain pass-through");

	a_step_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.gcd_step && cmd.div_step) && !(cmd.load && cmd.out_load))
		else $error("conflicting datapath commands");

endmodule
